@@ src/stp_ramp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid ramp package
// Shared codes, widths and register defaults of the trapezoidal stepper
// move profiler.
// ----------------------------------------------------------------------------
package stp_ramp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DivW     = 32;
  localparam int unsigned StepCntW = 31;
  localparam int unsigned AccelW   = 30;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_PERIOD = 2'd1,
    KIND_EVAL   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACCEL  = 2'd1,
    PH_CRUISE = 2'd2,
    PH_DECEL  = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_PERIOD   = 3'd0,
    CFG_CRUISE_PERIOD  = 3'd1,
    CFG_PERIOD_FLOOR   = 3'd2,
    CFG_PERIOD_CEILING = 3'd3,
    CFG_RAMP_TICKS     = 3'd4,
    CFG_SPEED_FLOOR    = 3'd5,
    CFG_TOP_SPEED      = 3'd6,
    CFG_UNUSED         = 3'd7
  } cfg_idx_e;

  localparam logic [15:0] RstStartPeriod   = 16'd1000;
  localparam logic [15:0] RstCruisePeriod  = 16'd720;
  localparam logic [15:0] RstPeriodFloor   = 16'd720;
  localparam logic [15:0] RstPeriodCeiling = 16'd1000;
  localparam logic [7:0]  RstRampTicks     = 8'd35;
  localparam logic [15:0] RstSpeedFloor    = 16'd10;
  localparam logic [15:0] RstTopSpeed      = 16'd100;

  localparam logic [15:0] SpeedMax   = 16'hFFFF;
  localparam logic [7:0]  RampCntMax = 8'hFF;

endpackage

@@ src/stepper_trapezoid_ramp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoidal stepper move profiler
// Splits a move into acceleration, cruise and deceleration, counts steps and
// position, ramps the timer period and steps the duty value.
// ----------------------------------------------------------------------------
// Start and evaluate beats go from acceptance through S_DIV and S_DONE to the
// result beat: one shared restoring divider runs 32 compare-and-subtract steps,
// giving the speed interval for a start beat and the step count remainder for
// an evaluate beat. Period-end beats and unused kinds go straight to S_DONE.
// One beat is worked on at a time; the output register holds a finished result
// while the next beat is accepted. Configuration is to be written by the user
// only while the block is idle; the block itself does not enforce this.
module stepper_trapezoid_ramp #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 cfg_we_i,
  input  logic [stp_ramp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [stp_ramp_pkg::CfgDataW-1:0]    cfg_wdata_i,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           kind_i,
  input  logic [stp_ramp_pkg::StepCntW-1:0]    step_count_i,
  input  logic                                 direction_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [15:0]                          timer_period_o,
  output logic [15:0]                          duty_o,
  output logic [1:0]                           phase_o,
  output logic signed [31:0]                   position_o,
  output logic                                 motor_enable_o,
  output logic                                 move_done_o
);
  import stp_ramp_pkg::*;

  localparam int unsigned IterW = $clog2(DivW);
  localparam logic [IterW-1:0] IterLast = IterW'(DivW - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q;

  logic [15:0] start_period_q, cruise_period_q, period_floor_q, period_ceiling_q;
  logic [7:0]  ramp_ticks_q;
  logic [15:0] speed_floor_q, top_speed_q;

  kind_e                kind_q;
  logic [StepCntW-1:0]  count_q;
  logic                 dir_q;

  logic [DivW-1:0]      rem_q, quo_q;
  logic [AccelW-1:0]    dvs_q;
  logic [IterW-1:0]     iter_q;

  phase_e               phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] steps_taken_q, steps_taken_d;
  logic [StepCntW-1:0]  steps_total_q, steps_total_d;
  logic [AccelW-1:0]    accel_steps_q, accel_steps_d;
  logic [StepCntW-1:0]  cruise_steps_q, cruise_steps_d;
  logic [AccelW-1:0]    speed_interval_q, speed_interval_d;
  logic [COUNT_WIDTH-1:0] cruise_end_q, cruise_end_d;
  logic [15:0]          speed_q, speed_d;
  logic [15:0]          ramp_period_q, ramp_period_d;
  logic [15:0]          reload_q, reload_d;
  logic [7:0]           ramp_cnt_q, ramp_cnt_d;
  logic [31:0]          position_q, position_d;
  logic                 done_q, done_d;
  logic                 enable_q, enable_d;

  logic                 out_valid_q;
  logic [15:0]          out_period_q, out_duty_q;
  phase_e               out_phase_q;
  logic [31:0]          out_position_q;
  logic                 out_enable_q, out_done_q;

  logic                 in_accept;
  logic                 out_free;
  logic [DivW:0]        div_shift, div_diff;
  logic [DivW-1:0]      div_dividend;
  logic [AccelW-1:0]    div_divisor;
  logic [31:0]          steps_ext, sum_end;
  logic [7:0]           ramp_cnt_inc;
  logic                 rem_zero;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign steps_ext = 32'(steps_taken_q);

  always_comb begin
    if (kind_e'(kind_i) == KIND_START) begin
      div_dividend = DivW'(step_count_i[StepCntW-1:2]);
      div_divisor  = (top_speed_q == '0) ? AccelW'(1) : AccelW'(top_speed_q);
    end else begin
      div_dividend = DivW'(steps_taken_q);
      div_divisor  = (speed_interval_q == '0) ? AccelW'(1) : speed_interval_q;
    end
  end

  assign div_shift = {rem_q, quo_q[DivW-1]};
  assign div_diff  = div_shift - (DivW+1)'(dvs_q);
  assign rem_zero  = (rem_q == '0);

  assign ramp_cnt_inc = (ramp_cnt_q < RampCntMax) ? ramp_cnt_q + 8'd1 : ramp_cnt_q;
  assign sum_end      = steps_ext + 32'(cruise_steps_q);

  always_comb begin
    phase_d          = phase_q;
    steps_taken_d    = steps_taken_q;
    steps_total_d    = steps_total_q;
    accel_steps_d    = accel_steps_q;
    cruise_steps_d   = cruise_steps_q;
    speed_interval_d = speed_interval_q;
    cruise_end_d     = cruise_end_q;
    speed_d          = speed_q;
    ramp_period_d    = ramp_period_q;
    reload_d         = reload_q;
    ramp_cnt_d       = ramp_cnt_q;
    position_d       = position_q;
    done_d           = done_q;
    enable_d         = enable_q;

    case (kind_q)
      KIND_START: begin
        steps_total_d    = count_q;
        accel_steps_d    = AccelW'(count_q[StepCntW-1:2]);
        cruise_steps_d   = count_q - StepCntW'({count_q[StepCntW-1:2], 1'b0});
        speed_interval_d = quo_q[AccelW-1:0];
        phase_d          = PH_ACCEL;
        speed_d          = 16'd1;
        ramp_period_d    = start_period_q;
        reload_d         = start_period_q;
        enable_d         = 1'b1;
        done_d           = 1'b0;
      end
      KIND_PERIOD: begin
        steps_taken_d = steps_taken_q + COUNT_WIDTH'(1);
        position_d    = dir_q ? position_q + 32'd1 : position_q - 32'd1;
        ramp_cnt_d    = ramp_cnt_inc;
        if (phase_q == PH_ACCEL && ramp_cnt_inc >= ramp_ticks_q) begin
          ramp_cnt_d = '0;
          if (ramp_period_q > period_floor_q) begin
            ramp_period_d = ramp_period_q - 16'd1;
            reload_d      = ramp_period_q - 16'd1;
          end
        end else if (phase_q == PH_DECEL && ramp_cnt_inc >= ramp_ticks_q) begin
          ramp_cnt_d = '0;
          if (ramp_period_q < period_ceiling_q) begin
            ramp_period_d = ramp_period_q + 16'd1;
            reload_d      = ramp_period_q + 16'd1;
          end
        end
      end
      KIND_EVAL: begin
        unique case (phase_q)
          PH_ACCEL: begin
            if (accel_steps_q != '0 && steps_ext >= 32'(accel_steps_q)) begin
              reload_d     = cruise_period_q;
              cruise_end_d = sum_end[COUNT_WIDTH-1:0];
              phase_d      = PH_CRUISE;
            end else begin
              if (accel_steps_q == '0) begin
                phase_d = PH_DECEL;
              end
              if (speed_q <= ramp_period_q && rem_zero && speed_q != SpeedMax) begin
                speed_d = speed_q + 16'd1;
              end
            end
          end
          PH_CRUISE: begin
            if (steps_ext >= 32'(cruise_end_q)) begin
              phase_d = PH_DECEL;
            end
          end
          PH_DECEL: begin
            if (steps_ext >= 32'(steps_total_q)) begin
              phase_d = PH_IDLE;
            end else if (speed_q >= speed_floor_q && rem_zero && speed_q != '0) begin
              speed_d = speed_q - 16'd1;
            end
          end
          PH_IDLE: begin
            enable_d         = 1'b0;
            steps_taken_d    = '0;
            speed_d          = '0;
            accel_steps_d    = '0;
            cruise_steps_d   = '0;
            speed_interval_d = '0;
            steps_total_d    = '0;
            cruise_end_d     = '0;
            done_d           = 1'b1;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_period_q   <= RstStartPeriod;
      cruise_period_q  <= RstCruisePeriod;
      period_floor_q   <= RstPeriodFloor;
      period_ceiling_q <= RstPeriodCeiling;
      ramp_ticks_q     <= RstRampTicks;
      speed_floor_q    <= RstSpeedFloor;
      top_speed_q      <= RstTopSpeed;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_PERIOD:   start_period_q   <= cfg_wdata_i;
        CFG_CRUISE_PERIOD:  cruise_period_q  <= cfg_wdata_i;
        CFG_PERIOD_FLOOR:   period_floor_q   <= cfg_wdata_i;
        CFG_PERIOD_CEILING: period_ceiling_q <= cfg_wdata_i;
        CFG_RAMP_TICKS:     ramp_ticks_q     <= cfg_wdata_i[7:0];
        CFG_SPEED_FLOOR:    speed_floor_q    <= cfg_wdata_i;
        CFG_TOP_SPEED:      top_speed_q      <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      kind_q           <= KIND_NONE;
      count_q          <= '0;
      dir_q            <= 1'b0;
      rem_q            <= '0;
      quo_q            <= '0;
      dvs_q            <= '0;
      iter_q           <= '0;
      phase_q          <= PH_IDLE;
      steps_taken_q    <= '0;
      steps_total_q    <= '0;
      accel_steps_q    <= '0;
      cruise_steps_q   <= '0;
      speed_interval_q <= '0;
      cruise_end_q     <= '0;
      speed_q          <= '0;
      ramp_period_q    <= '0;
      reload_q         <= '0;
      ramp_cnt_q       <= '0;
      position_q       <= '0;
      done_q           <= 1'b0;
      enable_q         <= 1'b0;
      out_valid_q      <= 1'b0;
      out_period_q     <= '0;
      out_duty_q       <= '0;
      out_phase_q      <= PH_IDLE;
      out_position_q   <= '0;
      out_enable_q     <= 1'b0;
      out_done_q       <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            kind_q  <= kind_e'(kind_i);
            count_q <= step_count_i;
            dir_q   <= direction_i;
            rem_q   <= '0;
            quo_q   <= div_dividend;
            dvs_q   <= div_divisor;
            iter_q  <= '0;
            if (kind_e'(kind_i) == KIND_START || kind_e'(kind_i) == KIND_EVAL) begin
              state_q <= S_DIV;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_DIV: begin
          if (!div_diff[DivW]) begin
            rem_q <= div_diff[DivW-1:0];
            quo_q <= {quo_q[DivW-2:0], 1'b1};
          end else begin
            rem_q <= div_shift[DivW-1:0];
            quo_q <= {quo_q[DivW-2:0], 1'b0};
          end
          iter_q <= iter_q + IterW'(1);
          if (iter_q == IterLast) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            phase_q          <= phase_d;
            steps_taken_q    <= steps_taken_d;
            steps_total_q    <= steps_total_d;
            accel_steps_q    <= accel_steps_d;
            cruise_steps_q   <= cruise_steps_d;
            speed_interval_q <= speed_interval_d;
            cruise_end_q     <= cruise_end_d;
            speed_q          <= speed_d;
            ramp_period_q    <= ramp_period_d;
            reload_q         <= reload_d;
            ramp_cnt_q       <= ramp_cnt_d;
            position_q       <= position_d;
            done_q           <= done_d;
            enable_q         <= enable_d;
            out_valid_q      <= 1'b1;
            out_period_q     <= reload_d;
            out_duty_q       <= speed_d;
            out_phase_q      <= phase_d;
            out_position_q   <= position_d;
            out_enable_q     <= enable_d;
            out_done_q       <= done_d;
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign timer_period_o = out_period_q;
  assign duty_o         = out_duty_q;
  assign phase_o        = out_phase_q;
  assign position_o     = signed'(out_position_q);
  assign motor_enable_o = out_enable_q;
  assign move_done_o    = out_done_q;

endmodule
